/* design/npf_pkg.sv */
package npf_pkg;

    // fixed point scale, Q2.14
    localparam int ONE_Q  = 16384;
    localparam int HALF_Q = 8192;

    // default maximum smoothstep pass count
    localparam int MAX_PASSES_DEF = 4;

    // stages from input register to remap result
    localparam int REMAP_LAT = 14;

    // filter modes (code 7 is unused and passes the sample, clamped to [0,1])
    typedef enum logic [2:0] {
        MODE_REMAP    = 3'd0,
        MODE_CONTRAST = 3'd1,
        MODE_FLATTEN  = 3'd2,
        MODE_INCREASE = 3'd3,
        MODE_MIN      = 3'd4,
        MODE_MAX      = 3'd5,
        MODE_CLAMP    = 3'd6
    } mode_t;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_MODE       = 3'd0,
        REG_INVERT     = 3'd1,
        REG_LEVEL_LOW  = 3'd2,
        REG_LEVEL_HIGH = 3'd3,
        REG_NEW_LOW    = 3'd4,
        REG_NEW_HIGH   = 3'd5,
        REG_PASSES     = 3'd6,
        REG_QUINTIC    = 3'd7
    } reg_idx_t;

    // two restoring division steps: returns {quotient bits, remainder}
    function automatic logic [19:0] div2(logic [17:0] rem, logic [1:0] bits,
                                         logic [17:0] d);
        logic [18:0] r;
        logic [1:0]  q;
        r    = {rem, bits[1]};
        q[1] = (r >= {1'b0, d});
        if (q[1]) begin
            r = r - {1'b0, d};
        end
        r    = {r[17:0], bits[0]};
        q[0] = (r >= {1'b0, d});
        if (q[0]) begin
            r = r - {1'b0, d};
        end
        return {q, r[17:0]};
    endfunction

endpackage

/* design/noise_point_filter_core.sv */
// throughput: one word per cycle when the output is not stalled, set by a fully pipelined
// datapath with one smoothstep pass per three stages and a two-bit-per-stage remap divider
// a stall on the output freezes the whole pipeline; nothing is dropped
// reset (synchronous, aresetn low) clears all valid bits and loads register defaults
module noise_point_filter_core #(
    parameter int MAX_PASSES = npf_pkg::MAX_PASSES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [15:0] sample, [30:16] strength
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [15:0] result
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int CON_LAT   = 3 * MAX_PASSES;
    localparam int BLEND_LAT = CON_LAT + 3;
    localparam int REMAP_LAT = npf_pkg::REMAP_LAT;
    localparam int LAT       = (BLEND_LAT > REMAP_LAT) ? BLEND_LAT + 1 : REMAP_LAT + 1;

    // configuration registers
    logic [2:0]         mode_reg;
    logic               invert_reg;
    logic signed [15:0] level_low_reg;
    logic signed [15:0] level_high_reg;
    logic signed [15:0] new_low_reg;
    logic signed [15:0] new_high_reg;
    logic [2:0]         passes_reg;
    logic               quintic_reg;

    assign cfg_ready = 1'b1;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= 3'd2;
            invert_reg     <= 1'b0;
            level_low_reg  <= 16'sd0;
            level_high_reg <= 16'sd16384;
            new_low_reg    <= 16'sd0;
            new_high_reg   <= 16'sd16384;
            passes_reg     <= 3'd1;
            quintic_reg    <= 1'b0;
        end else if (cfg_valid) begin
            unique case (npf_pkg::reg_idx_t'(cfg_index))
                npf_pkg::REG_MODE:       mode_reg       <= cfg_data[2:0];
                npf_pkg::REG_INVERT:     invert_reg     <= cfg_data[0];
                npf_pkg::REG_LEVEL_LOW:  level_low_reg  <= cfg_data;
                npf_pkg::REG_LEVEL_HIGH: level_high_reg <= cfg_data;
                npf_pkg::REG_NEW_LOW:    new_low_reg    <= cfg_data;
                npf_pkg::REG_NEW_HIGH:   new_high_reg   <= cfg_data;
                npf_pkg::REG_PASSES:     passes_reg     <= cfg_data[2:0];
                npf_pkg::REG_QUINTIC:    quintic_reg    <= cfg_data[0];
                default:                 mode_reg       <= mode_reg;
            endcase
        end
    end

    // global pipeline advance
    logic ce;
    assign ce       = !m_tvalid || m_tready;
    assign s_tready = ce;

    logic                valid_reg    [0:LAT];
    logic signed [15:0]  sample_reg   [0:CON_LAT+2];
    logic        [14:0]  strength_reg [0:CON_LAT+1];

    // valid chain and input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k <= LAT; k++) begin
                valid_reg[k] <= 1'b0;
            end
        end else if (ce) begin
            valid_reg[0] <= s_tvalid;
            for (int k = 1; k <= LAT; k++) begin
                valid_reg[k] <= valid_reg[k-1];
            end
        end
    end

    // sample and strength travel with the word
    always_ff @(posedge aclk) begin
        if (ce) begin
            sample_reg[0]   <= s_tdata[15:0];
            strength_reg[0] <= s_tdata[30:16];
            for (int k = 1; k <= CON_LAT + 2; k++) begin
                sample_reg[k] <= sample_reg[k-1];
            end
            for (int k = 1; k <= CON_LAT + 1; k++) begin
                strength_reg[k] <= strength_reg[k-1];
            end
        end
    end

    // ---------------- contrast: three stages per smoothstep pass ----------------
    logic signed [15:0] ctr_in [0:MAX_PASSES];
    logic        [14:0] pa_t_reg   [0:MAX_PASSES-1];
    logic        [14:0] pa_p_reg   [0:MAX_PASSES-1];
    logic        [17:0] pa_w_reg   [0:MAX_PASSES-1];
    logic signed [15:0] pa_h_reg   [0:MAX_PASSES-1];
    logic               pa_act_reg [0:MAX_PASSES-1];
    logic        [14:0] pb_cub_reg [0:MAX_PASSES-1];
    logic        [14:0] pb_c_reg   [0:MAX_PASSES-1];
    logic        [17:0] pb_w_reg   [0:MAX_PASSES-1];
    logic signed [15:0] pb_h_reg   [0:MAX_PASSES-1];
    logic               pb_act_reg [0:MAX_PASSES-1];
    logic signed [15:0] pc_out_reg [0:MAX_PASSES-1];

    assign ctr_in[0] = sample_reg[0];

    for (genvar p = 0; p < MAX_PASSES; p++) begin : g_pass
        logic        [14:0] t_next;
        logic        [29:0] sq;
        logic signed [19:0] t_s;
        logic signed [19:0] lin;
        logic signed [39:0] wprod;
        logic        [14:0] p_next;
        logic        [17:0] w_next;
        logic        [15:0] m;
        logic        [31:0] cub_full;
        logic        [29:0] c_full;
        logic        [33:0] q_full;
        logic signed [15:0] out_next;
        logic               act_next;

        // clamp, square and quintic weight
        always_comb begin
            if (ctr_in[p] < 16'sd0) begin
                t_next = 15'd0;
            end else if (ctr_in[p] > 16'sd16384) begin
                t_next = 15'd16384;
            end else begin
                t_next = ctr_in[p][14:0];
            end
            sq     = 30'(t_next) * 30'(t_next);
            p_next = 15'((sq + 30'(npf_pkg::HALF_Q)) >> 14);
            t_s    = signed'({5'd0, t_next});
            lin    = 20'sd6 * t_s - 20'sd245760;
            wprod  = t_s * lin;
            w_next = 18'((wprod + 40'sd2684362752) >>> 14);
            act_next = (mode_reg == npf_pkg::MODE_CONTRAST) && (passes_reg > 3'(p));
        end

        // cubic term and t cubed
        always_comb begin
            m        = 16'(17'd49152 - {1'b0, pa_t_reg[p], 1'b0});
            cub_full = 32'(pa_p_reg[p]) * 32'(m) + 32'(npf_pkg::HALF_Q);
            c_full   = 30'(pa_p_reg[p]) * 30'(pa_t_reg[p]) + 30'(npf_pkg::HALF_Q);
        end

        // quintic product or cubic result; an inactive pass hands its input through
        always_comb begin
            q_full = 34'(pb_c_reg[p]) * 34'(pb_w_reg[p]) + 34'(npf_pkg::HALF_Q);
            if (!pb_act_reg[p]) begin
                out_next = pb_h_reg[p];
            end else if (quintic_reg) begin
                out_next = signed'({1'b0, 15'(q_full >> 14)});
            end else begin
                out_next = signed'({1'b0, pb_cub_reg[p]});
            end
        end

        always_ff @(posedge aclk) begin
            if (ce) begin
                pa_t_reg[p]   <= t_next;
                pa_p_reg[p]   <= p_next;
                pa_w_reg[p]   <= w_next;
                pa_h_reg[p]   <= ctr_in[p];
                pa_act_reg[p] <= act_next;
                pb_cub_reg[p] <= 15'(cub_full >> 14);
                pb_c_reg[p]   <= 15'(c_full >> 14);
                pb_w_reg[p]   <= pa_w_reg[p];
                pb_h_reg[p]   <= pa_h_reg[p];
                pb_act_reg[p] <= pa_act_reg[p];
                pc_out_reg[p] <= out_next;
            end
        end

        assign ctr_in[p+1] = pc_out_reg[p];
    end

    // ---------------- point operation, invert and blend ----------------
    logic signed [16:0] s17;
    logic signed [16:0] ll17;
    logic signed [16:0] lh17;
    logic signed [16:0] pre17;
    logic signed [17:0] d_next;
    logic signed [17:0] d_reg;
    logic signed [33:0] prod_reg;
    logic signed [19:0] blend_q;
    logic signed [20:0] blend_sum;
    logic signed [15:0] blend_next;
    logic signed [15:0] blend_pipe_reg [BLEND_LAT:LAT];

    // pick the filtered value and form its offset from the sample, negated when invert is set
    always_comb begin
        s17  = 17'(sample_reg[CON_LAT]);
        ll17 = 17'(level_low_reg);
        lh17 = 17'(level_high_reg);
        unique case (mode_reg)
            npf_pkg::MODE_CONTRAST: pre17 = 17'(ctr_in[MAX_PASSES]);
            npf_pkg::MODE_FLATTEN:  pre17 = ll17;
            npf_pkg::MODE_INCREASE: pre17 = s17 + ll17;
            npf_pkg::MODE_MIN:      pre17 = (s17 < ll17) ? s17 : ll17;
            npf_pkg::MODE_MAX:      pre17 = (s17 > lh17) ? s17 : lh17;
            npf_pkg::MODE_CLAMP: begin
                if (s17 < ll17) begin
                    pre17 = ll17;
                end else if (s17 > lh17) begin
                    pre17 = lh17;
                end else begin
                    pre17 = s17;
                end
            end
            default:                pre17 = s17;
        endcase
        if (invert_reg) begin
            d_next = 18'(s17) - 18'(pre17);
        end else begin
            d_next = 18'(pre17) - 18'(s17);
        end
    end

    // rounded lerp from the sample, clamped to [0,1]
    always_comb begin
        blend_q   = 20'((prod_reg + 34'sd8192) >>> 14);
        blend_sum = 21'(sample_reg[CON_LAT+2]) + 21'(blend_q);
        if (blend_sum < 21'sd0) begin
            blend_next = 16'sd0;
        end else if (blend_sum > 21'sd16384) begin
            blend_next = 16'sd16384;
        end else begin
            blend_next = blend_sum[15:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            d_reg                     <= d_next;
            prod_reg                  <= d_reg * signed'({1'b0, strength_reg[CON_LAT+1]});
            blend_pipe_reg[BLEND_LAT] <= blend_next;
            for (int k = BLEND_LAT + 1; k <= LAT; k++) begin
                blend_pipe_reg[k] <= blend_pipe_reg[k-1];
            end
        end
    end

    // ---------------- remap: multiply, then pipelined divide ----------------
    logic signed [16:0] rm_a_reg;
    logic signed [16:0] rm_b_reg;
    logic signed [16:0] rm_den_reg;
    logic signed [33:0] rm_num_reg;
    logic signed [16:0] rm_den2_reg;
    logic signed [35:0] rm_n_reg;
    logic        [17:0] rm_d_reg;
    logic               rm_zero_reg;
    logic signed [16:0] den_abs;
    logic signed [33:0] num_adj;
    logic        [35:0] nabs;

    logic [17:0] dv_rem_reg  [0:9];
    logic [17:0] dv_low_reg  [0:9];
    logic [17:0] dv_q_reg    [0:9];
    logic [17:0] dv_d_reg    [0:9];
    logic        dv_neg_reg  [0:9];
    logic        dv_zero_reg [0:9];
    logic        dv_big_reg  [0:9];

    logic signed [19:0] rm_q;
    logic signed [20:0] rm_sum;
    logic signed [15:0] remap_next;
    logic signed [15:0] remap_pipe_reg [REMAP_LAT:LAT];

    // normalize divisor sign and take the magnitude
    always_comb begin
        if (rm_den2_reg < 17'sd0) begin
            den_abs = -rm_den2_reg;
            num_adj = -rm_num_reg;
        end else begin
            den_abs = rm_den2_reg;
            num_adj = rm_num_reg;
        end
        nabs = (rm_n_reg < 36'sd0) ? 36'(-rm_n_reg) : 36'(rm_n_reg);
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            rm_a_reg      <= 17'(sample_reg[0]) - 17'(level_low_reg);
            rm_b_reg      <= 17'(new_high_reg) - 17'(new_low_reg);
            rm_den_reg    <= 17'(level_high_reg) - 17'(level_low_reg);
            rm_num_reg    <= rm_a_reg * rm_b_reg;
            rm_den2_reg   <= rm_den_reg;
            rm_n_reg      <= 36'(num_adj) * 36'sd2 + 36'(den_abs);
            rm_d_reg      <= {den_abs[16:0], 1'b0};
            rm_zero_reg   <= (rm_den2_reg == 17'sd0);
            dv_rem_reg[0]  <= nabs[35:18];
            dv_low_reg[0]  <= nabs[17:0];
            dv_q_reg[0]    <= 18'd0;
            dv_d_reg[0]    <= rm_d_reg;
            dv_neg_reg[0]  <= rm_n_reg < 36'sd0;
            dv_zero_reg[0] <= rm_zero_reg;
            dv_big_reg[0]  <= nabs >= {rm_d_reg, 18'd0};
        end
    end

    // two quotient bits per stage
    for (genvar j = 1; j < 10; j++) begin : g_div
        logic [19:0] step;
        assign step = npf_pkg::div2(dv_rem_reg[j-1], dv_low_reg[j-1][17:16], dv_d_reg[j-1]);

        always_ff @(posedge aclk) begin
            if (ce) begin
                dv_rem_reg[j]  <= step[17:0];
                dv_low_reg[j]  <= {dv_low_reg[j-1][15:0], 2'b00};
                dv_q_reg[j]    <= {dv_q_reg[j-1][15:0], step[19:18]};
                dv_d_reg[j]    <= dv_d_reg[j-1];
                dv_neg_reg[j]  <= dv_neg_reg[j-1];
                dv_zero_reg[j] <= dv_zero_reg[j-1];
                dv_big_reg[j]  <= dv_big_reg[j-1];
            end
        end
    end

    // floor correction, offset, zero-divisor fallback and saturation
    always_comb begin
        if (dv_neg_reg[9]) begin
            rm_q = -20'(dv_q_reg[9]) - ((dv_rem_reg[9] != 18'd0) ? 20'sd1 : 20'sd0);
        end else begin
            rm_q = 20'(dv_q_reg[9]);
        end
        rm_sum = 21'(new_low_reg) + 21'(rm_q);
        if (dv_zero_reg[9]) begin
            remap_next = new_low_reg;
        end else if (dv_big_reg[9]) begin
            remap_next = dv_neg_reg[9] ? -16'sd32768 : 16'sd32767;
        end else if (rm_sum > 21'sd32767) begin
            remap_next = 16'sd32767;
        end else if (rm_sum < -21'sd32768) begin
            remap_next = -16'sd32768;
        end else begin
            remap_next = rm_sum[15:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            remap_pipe_reg[REMAP_LAT] <= remap_next;
            for (int k = REMAP_LAT + 1; k <= LAT; k++) begin
                remap_pipe_reg[k] <= remap_pipe_reg[k-1];
            end
        end
    end

    // output word
    assign m_tvalid = valid_reg[LAT];
    assign m_tdata  = (mode_reg == npf_pkg::MODE_REMAP) ? remap_pipe_reg[LAT]
                                                        : blend_pipe_reg[LAT];

    // blended result always lands inside [0,1]
    a_blend_range: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg[BLEND_LAT] |->
            (blend_pipe_reg[BLEND_LAT] >= 16'sd0) && (blend_pipe_reg[BLEND_LAT] <= 16'sd16384))
        else $error("blend result out of range");

    // smoothstep output stays in [0,1] once a pass ran
    a_contrast_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg[CON_LAT] && (mode_reg == npf_pkg::MODE_CONTRAST) && (passes_reg != 3'd0)) |->
            (ctr_in[MAX_PASSES] >= 16'sd0) && (ctr_in[MAX_PASSES] <= 16'sd16384))
        else $error("contrast value out of range");

    // divider remainder below divisor when the quotient is in range
    a_div_rem: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg[REMAP_LAT-1] && !dv_zero_reg[9] && !dv_big_reg[9]) |->
            (dv_rem_reg[9] < dv_d_reg[9]))
        else $error("divider remainder not reduced");

endmodule
